FILE: rtl/core/taipid_pkg.sv
// Package for the three-axis incremental PID block.
// Holds widths, register indexes and the control struct shared by all modules.
// No dependencies.
package taipid_pkg;

    localparam int NAXES         = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int GAIN_W        = 24;
    localparam int K_W           = GAIN_W + 2;       // kp + ki + kd, kp + 2*kd
    localparam int VAL_W         = 32;
    localparam int ERR_W         = VAL_W + 1;
    localparam int PROD_W        = K_W + 1 + ERR_W;  // signed k times signed error
    localparam int ACC_W         = PROD_W + 2;
    localparam int IDX_W         = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_PROP  = 3'd0,
        REG_GAIN_INTEG = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_SETPOINT_X = 3'd3,
        REG_SETPOINT_Y = 3'd4,
        REG_SETPOINT_Z = 3'd5
    } taipid_reg_t;

    // derived loop coefficients, shared by all lanes
    typedef struct packed {
        logic [K_W-1:0] k0;
        logic [K_W-1:0] k1;
        logic [K_W-1:0] k2;
    } taipid_coef_t;

    // pipeline step strobes from the controller to each lane
    typedef struct packed {
        logic accept;   // input word taken into stage 1
        logic adv2;     // stage 2 loads from stage 1
        logic adv3;     // stage 3 loads from stage 2
        logic load4;    // output stage loads, drive state updates
    } taipid_step_t;

endpackage

FILE: rtl/core/three_axis_incremental_pid.sv
// Top level of the three-axis incremental (velocity-form) PID block.
// Instantiates taipid_cfg, taipid_ctrl and three taipid_lane; uses taipid_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: meas_x, meas_y, meas_z.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   drive_x, drive_y, drive_z and clip_flags (bit0 x, bit1 y, bit2 z saturated).
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes gains
//   (index 0..2) and setpoints (index 3..5); other indexes are ignored.
//   cfg_ready is always high; in_ready drops while cfg_valid is high, so the
//   derived coefficients are settled before the next word uses them.
// Stages from input accept to out_valid: error, multiply, rounded sum,
//   saturating add. Throughput: one word per cycle while out_ready is high
//   and cfg_valid low; limits: per-axis 27x33 multiply, drive add-saturate.
// Stall: when out_ready is low, words collect in the four stages; in_ready
//   falls only once all four hold a word, and resumes as soon as one moves.
// Reset: gains return to kp 2.0, ki 0.01, kd 0; setpoints to 0, 0, 4.0;
//   error history and previous drives clear to zero; no word is pending.
module three_axis_incremental_pid
    import taipid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [VAL_W-1:0] meas_x,
    input  logic signed [VAL_W-1:0] meas_y,
    input  logic signed [VAL_W-1:0] meas_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] drive_x,
    output logic signed [VAL_W-1:0] drive_y,
    output logic signed [VAL_W-1:0] drive_z,
    output logic [NAXES-1:0]        clip_flags,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VAL_W-1:0]        cfg_data
);

    taipid_coef_t                coef;
    taipid_step_t                step;
    logic [NAXES-1:0][VAL_W-1:0] setpoint;
    logic [NAXES-1:0][VAL_W-1:0] meas;
    logic [NAXES-1:0][VAL_W-1:0] drive;
    logic [NAXES-1:0]            clip;

    // config writes never stall
    assign cfg_ready = 1'b1;

    taipid_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .setpoint  (setpoint)
    );

    taipid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .step      (step)
    );

    assign meas = {meas_z, meas_y, meas_x};

    // one lane per axis, all stepping together
    for (genvar a = 0; a < NAXES; a++)
    begin : g_lane
        taipid_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (step),
            .coef     (coef),
            .setpoint ($signed(setpoint[a])),
            .meas     ($signed(meas[a])),
            .drive    (drive[a]),
            .clip     (clip[a])
        );
    end

    // merge: gather lane drives and clip bits into one result word
    assign drive_x    = $signed(drive[0]);
    assign drive_y    = $signed(drive[1]);
    assign drive_z    = $signed(drive[2]);
    assign clip_flags = clip;

endmodule

FILE: rtl/core/taipid_cfg.sv
// Configuration register file for the three-axis incremental PID block.
// Holds gains and setpoints and registers the derived coefficients k0, k1, k2.
// Depends on taipid_pkg.
module taipid_cfg
    import taipid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [IDX_W-1:0]              cfg_index,
    input  logic [VAL_W-1:0]              cfg_data,
    output taipid_coef_t                  coef,
    output logic [NAXES-1:0][VAL_W-1:0]   setpoint
);

    localparam logic [63:0] GP_RST_W = 64'd2 << FRAC_BITS;
    localparam logic [63:0] GI_RST_W = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [GAIN_W-1:0] GP_RST = GP_RST_W[GAIN_W-1:0];
    localparam logic [GAIN_W-1:0] GI_RST = GI_RST_W[GAIN_W-1:0];
    localparam logic [K_W-1:0] K0_RST = {2'b00, GP_RST} + {2'b00, GI_RST};
    localparam logic [K_W-1:0] K1_RST = {2'b00, GP_RST};
    localparam logic [VAL_W-1:0] SPZ_RST = 32'h0004_0000;   // 4.0

    logic [GAIN_W-1:0] gp_reg, gi_reg, gd_reg;
    logic [NAXES-1:0][VAL_W-1:0] sp_reg;
    taipid_coef_t coef_reg, coef_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg <= GP_RST;
            gi_reg <= GI_RST;
            gd_reg <= '0;
            sp_reg <= {SPZ_RST, {VAL_W{1'b0}}, {VAL_W{1'b0}}};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_PROP:  gp_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEG: gi_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV: gd_reg    <= cfg_data[GAIN_W-1:0];
                REG_SETPOINT_X: sp_reg[0] <= cfg_data;
                REG_SETPOINT_Y: sp_reg[1] <= cfg_data;
                REG_SETPOINT_Z: sp_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        coef_next.k0 = {2'b00, gp_reg} + {2'b00, gi_reg} + {2'b00, gd_reg};
        coef_next.k1 = {2'b00, gp_reg} + {1'b0, gd_reg, 1'b0};
        coef_next.k2 = {2'b00, gd_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.k0 <= K0_RST;
            coef_reg.k1 <= K1_RST;
            coef_reg.k2 <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef     = coef_reg;
    assign setpoint = sp_reg;

endmodule

FILE: rtl/core/taipid_ctrl.sv
// Pipeline controller for the three-axis incremental PID block.
// Tracks stage valid bits, forms per-stage load strobes and the handshakes.
// Depends on taipid_pkg.
module taipid_ctrl
    import taipid_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         cfg_valid,
    input  logic         out_ready,
    output logic         in_ready,
    output logic         out_valid,
    output taipid_step_t step
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic accept;

    // a stage can load when empty or when its word moves on this cycle
    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    // hold off inputs while a config write is pending, so coefficients settle
    assign in_ready = rdy1 && !cfg_valid;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        v1_next = rdy1 ? accept : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign step.accept = accept;
    assign step.adv2   = rdy2 && v1_reg;
    assign step.adv3   = rdy3 && v2_reg;
    assign step.load4  = rdy4 && v3_reg;
    assign out_valid   = v4_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step.accept |=> v1_reg)
        else $error("accepted word did not reach stage 1");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step.load4 |=> v4_reg)
        else $error("output stage load lost");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !rdy1 |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input blocked with a bubble in the pipeline");

    a_no_cfg_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> !step.accept)
        else $error("input accepted during config write");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !rdy2) |=> v1_reg)
        else $error("stage 1 word dropped while stalled");

endmodule

FILE: rtl/core/taipid_lane.sv
// One PID axis lane: error history, three products, rounded sum, saturating drive.
// Four stages, driven by the step strobes of taipid_ctrl.
// Depends on taipid_pkg.
module taipid_lane
    import taipid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  taipid_step_t            step,
    input  taipid_coef_t            coef,
    input  logic signed [VAL_W-1:0] setpoint,
    input  logic signed [VAL_W-1:0] meas,
    output logic signed [VAL_W-1:0] drive,
    output logic                    clip
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    logic signed [ERR_W-1:0]  e_now;
    logic signed [ERR_W-1:0]  hist_last_reg, hist_prev_reg;
    logic signed [ERR_W-1:0]  e0_reg, e1_reg, e2_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [ACC_W-1:0]  acc, acc_rnd, rs_next, rs_reg;
    logic signed [ACC_W-1:0]  sum;
    logic signed [VAL_W-1:0]  drive_reg, drive_next;
    logic                     clip_reg, clip_next;
    logic                     pos_ovf, neg_ovf;

    assign e_now = {setpoint[VAL_W-1], setpoint} - {meas[VAL_W-1], meas};

    // error history is loop state: shifts only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_last_reg <= '0;
            hist_prev_reg <= '0;
        end
        else if (step.accept)
        begin
            hist_last_reg <= e_now;
            hist_prev_reg <= hist_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.accept)
        begin
            e0_reg <= e_now;
            e1_reg <= hist_last_reg;
            e2_reg <= hist_prev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.adv2)
        begin
            p0_reg <= $signed({1'b0, coef.k0}) * e0_reg;
            p1_reg <= $signed({1'b0, coef.k1}) * e1_reg;
            p2_reg <= $signed({1'b0, coef.k2}) * e2_reg;
        end
    end

    // round to nearest, ties up: add half then floor shift
    always_comb
    begin
        acc     = ACC_W'(p0_reg) - ACC_W'(p1_reg) + ACC_W'(p2_reg);
        acc_rnd = acc + HALF;
        rs_next = acc_rnd >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (step.adv3)
        begin
            rs_reg <= rs_next;
        end
    end

    always_comb
    begin
        sum     = ACC_W'(drive_reg) + rs_reg;
        pos_ovf = !sum[ACC_W-1] && (|sum[ACC_W-2:VAL_W-1]);
        neg_ovf = sum[ACC_W-1] && !(&sum[ACC_W-2:VAL_W-1]);
        if (pos_ovf)
        begin
            drive_next = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (neg_ovf)
        begin
            drive_next = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            drive_next = sum[VAL_W-1:0];
        end
        clip_next = pos_ovf || neg_ovf;
    end

    // output register doubles as the stored previous drive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= '0;
            clip_reg  <= 1'b0;
        end
        else if (step.load4)
        begin
            drive_reg <= drive_next;
            clip_reg  <= clip_next;
        end
    end

    assign drive = drive_reg;
    assign clip  = clip_reg;

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for three_axis_incremental_pid: drives measurement words and
// register writes, predicts each drive word and checks it field by field.
// Depends on taipid_pkg and the three_axis_incremental_pid RTL.
module tb;

    import taipid_pkg::*;

    localparam int FRAC            = FRAC_BITS_DEF;
    localparam int RESET_CYCLES    = 11;
    localparam int LATENCY         = 4;      // extra drain wait in settle() and at the end
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 242;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 48;     // long enough to fill all four stages
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int N_PROBE         = 17;

    localparam logic [GAIN_W-1:0] GAIN_MAX  = '1;
    localparam logic [GAIN_W-1:0] GAIN_HALF = 24'h00_8000;  // 0.5, rounding ties galore
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC - 1);
    localparam longint DRIVE_MAX  = 64'sd2147483647;
    localparam longint DRIVE_MIN  = -64'sd2147483648;

    // indexes past the last register; writes there must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_A = IDX_W'(REG_SETPOINT_Z + 1);
    localparam logic [IDX_W-1:0] REG_SPARE_B = IDX_W'(REG_SETPOINT_Z + 2);

    // axis 0 is x, 1 is y, 2 is z; concatenations read {z, y, x}
    typedef logic [NAXES-1:0][VAL_W-1:0] meas_word_t;

    typedef struct packed {
        logic [NAXES-1:0][VAL_W-1:0] drive;
        logic [NAXES-1:0]            clip;
    } drive_word_t;

    typedef struct packed {
        meas_word_t  meas;
        logic        typed;   // want holds a hand-worked answer
        drive_word_t want;
    } probe_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [VAL_W-1:0] meas_x = '0;
    logic signed [VAL_W-1:0] meas_y = '0;
    logic signed [VAL_W-1:0] meas_z = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [VAL_W-1:0] drive_x;
    logic signed [VAL_W-1:0] drive_y;
    logic signed [VAL_W-1:0] drive_z;
    logic [NAXES-1:0]        clip_flags;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [VAL_W-1:0]        cfg_data = '0;

    // predictor copy of the registers and of the per-axis loop history
    logic [GAIN_W-1:0]       kp_gain;
    logic [GAIN_W-1:0]       ki_gain;
    logic [GAIN_W-1:0]       kd_gain;
    logic signed [VAL_W-1:0] target     [NAXES];
    logic signed [ERR_W-1:0] err_prev   [NAXES];
    logic signed [ERR_W-1:0] err_prev2  [NAXES];
    logic signed [VAL_W-1:0] drive_prev [NAXES];

    drive_word_t pending_drives [$];
    drive_word_t seen_word;
    drive_word_t oldest_word;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          gap_pct = 0;     // sender idles before a word in this share of tries
    int          stall_pct = 0;   // receiver drops out_ready in this share of cycles
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    string       axis_name [NAXES] = '{"x", "y", "z"};

    // Directed words, run with the reset registers (kp 2.0, ki 0.01, kd 0,
    // targets 0, 0, 4.0). The first three are worked by hand: on target gives
    // zero, then x at the negative rail overshoots high and clamps, then x at
    // the positive rail swings the drive past the low rail.
    probe_row_t probe_rows [N_PROBE] = '{
        '{ {32'h0004_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
           '{ {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 3'b000 } },
        '{ {32'h0004_0000, 32'h0000_0000, 32'h8000_0000}, 1'b1,
           '{ {32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff}, 3'b001 } },
        '{ {32'h0004_0000, 32'h0000_0000, 32'h7fff_ffff}, 1'b1,
           '{ {32'h0000_0000, 32'h0000_0000, 32'h8000_0000}, 3'b001 } },
        '{ {32'h0004_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0 },
        '{ {32'h0004_0000, 32'h8000_0000, 32'h0000_0000}, 1'b0, '0 },
        '{ {32'h0004_0000, 32'h7fff_ffff, 32'h0000_0000}, 1'b0, '0 },
        '{ {32'h8000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0 },
        '{ {32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0 },
        '{ {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, '0 },
        '{ {32'h5555_5555, 32'h5555_5555, 32'h5555_5555}, 1'b0, '0 },
        '{ {32'haaaa_aaaa, 32'haaaa_aaaa, 32'haaaa_aaaa}, 1'b0, '0 },
        '{ {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0 },
        '{ {32'h0004_0001, 32'hffff_ffff, 32'h0000_0001}, 1'b0, '0 },
        '{ {32'h0000_0000, 32'hffff_0000, 32'h0001_0000}, 1'b0, '0 },
        '{ {32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0 },
        '{ {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0 },
        '{ {32'h0004_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0 }
    };

    three_axis_incremental_pid #(
        .FRAC_BITS (FRAC)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .meas_x     (meas_x),
        .meas_y     (meas_y),
        .meas_z     (meas_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive_x    (drive_x),
        .drive_y    (drive_y),
        .drive_z    (drive_z),
        .clip_flags (clip_flags),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Velocity-form update for all three axes; advances the loop history.
    // Products and their sum stay below 2^60, so 64-bit math is exact.
    function automatic drive_word_t predict_step(input meas_word_t meas);
        longint      k0;
        longint      k1;
        longint      k2;
        longint      e0;
        longint      acc;
        longint      drv;
        drive_word_t next;
        next = '0;
        k0 = longint'(kp_gain) + longint'(ki_gain) + longint'(kd_gain);
        k1 = longint'(kp_gain) + 2 * longint'(kd_gain);
        k2 = longint'(kd_gain);
        for (int a = 0; a < NAXES; a++)
        begin
            e0  = longint'(target[a]) - longint'($signed(meas[a]));
            acc = k0 * e0 - k1 * longint'(err_prev[a]) + k2 * longint'(err_prev2[a]);
            // round half up: add half an LSB, then floor shift
            drv = longint'(drive_prev[a]) + ((acc + ROUND_HALF) >>> FRAC);
            if (drv > DRIVE_MAX)
            begin
                drv = DRIVE_MAX;
                next.clip[a] = 1'b1;
            end
            else if (drv < DRIVE_MIN)
            begin
                drv = DRIVE_MIN;
                next.clip[a] = 1'b1;
            end
            err_prev2[a]  = err_prev[a];
            err_prev[a]   = e0[ERR_W-1:0];
            drive_prev[a] = drv[VAL_W-1:0];
            next.drive[a] = drv[VAL_W-1:0];
        end
        return next;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Offer one measurement word and hold it until taken. Valid stays high
    // afterwards, so back-to-back words need no gap.
    task automatic send_word(input meas_word_t w, input logic typed,
                             input drive_word_t want);
        drive_word_t predicted;
        @(negedge clk);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            do @(negedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid = 1'b1;
        meas_x   = w[0];
        meas_y   = w[1];
        meas_z   = w[2];
        do @(posedge clk); while (!in_ready);
        // the predictor runs on every word to keep its history in step
        predicted = predict_step(w);
        pending_drives.push_back(typed ? want : predicted);
    endtask

    // Register write; cfg_valid is left high for the next write of a batch.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GAIN_PROP:  kp_gain   = data[GAIN_W-1:0];
            REG_GAIN_INTEG: ki_gain   = data[GAIN_W-1:0];
            REG_GAIN_DERIV: kd_gain   = data[GAIN_W-1:0];
            REG_SETPOINT_X: target[0] = data;
            REG_SETPOINT_Y: target[1] = data;
            REG_SETPOINT_Z: target[2] = data;
            default: ;
        endcase
    endtask

    // Stop offering and wait until every predicted drive word has come out.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_drives.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request so the four
    // stages fill and in_ready drops while the sender keeps offering.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= stall_pct);
    end

    // Drive word check against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_word.drive = {drive_z, drive_y, drive_x};
            seen_word.clip  = clip_flags;
            if (pending_drives.size() == 0)
                report($sformatf("drive word %h with none pending", seen_word));
            else
            begin
                oldest_word = pending_drives.pop_front();
                for (int a = 0; a < NAXES; a++)
                    if (seen_word.drive[a] !== oldest_word.drive[a])
                        report($sformatf("drive_%s got %h want %h", axis_name[a],
                                         seen_word.drive[a], oldest_word.drive[a]));
                if (seen_word.clip !== oldest_word.clip)
                    report($sformatf("clip_flags got %b want %b",
                                     seen_word.clip, oldest_word.clip));
            end
        end
    end

    // Watchdog: too long without any handshake on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        meas_word_t        word;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [VAL_W-1:0]  sp [NAXES];
        int                reach;

        // predictor state after reset
        kp_gain = GAIN_W'(2 << FRAC);
        ki_gain = GAIN_W'(((1 << FRAC) + 50) / 100);
        kd_gain = '0;
        target  = '{32'sd0, 32'sd0, 32'sd262144};
        for (int a = 0; a < NAXES; a++)
        begin
            err_prev[a]   = '0;
            err_prev2[a]  = '0;
            drive_prev[a] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words on the reset registers, no idling
        foreach (probe_rows[r])
            send_word(probe_rows[r].meas, probe_rows[r].typed, probe_rows[r].want);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            // registers change only with the block drained
            settle();
            case (phase)
                0:
                begin
                    kp = GAIN_MAX;
                    ki = GAIN_MAX;
                    kd = GAIN_MAX;
                    sp = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000};
                end
                1:
                begin
                    kp = '0;
                    ki = '0;
                    kd = '0;
                    sp = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
                end
                2:
                begin
                    // half gain alone: odd error steps land exactly on a half
                    kp = GAIN_HALF;
                    ki = '0;
                    kd = '0;
                    sp = '{$urandom, $urandom, $urandom};
                end
                default:
                begin
                    kp = GAIN_W'($urandom_range(24'h03_ffff));
                    ki = GAIN_W'($urandom_range(24'h00_3fff));
                    kd = GAIN_W'($urandom_range(24'h00_ffff));
                    sp = '{$urandom, $urandom, $urandom};
                end
            endcase
            // upper data bits on gain writes must be dropped
            write_reg(REG_GAIN_PROP,  ($urandom & 32'hff00_0000) | kp);
            write_reg(REG_GAIN_INTEG, ($urandom & 32'hff00_0000) | ki);
            write_reg(REG_GAIN_DERIV, ($urandom & 32'hff00_0000) | kd);
            write_reg(REG_SETPOINT_X, sp[0]);
            write_reg(REG_SETPOINT_Y, sp[1]);
            write_reg(REG_SETPOINT_Z, sp[2]);
            write_reg(phase[0] ? REG_SPARE_A : REG_SPARE_B, $urandom);
            @(negedge clk);
            cfg_valid = 1'b0;

            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 85; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 85; end
                default: begin gap_pct = 7;  stall_pct = 7;  end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // mostly near target so the drive moves without pinning at a
                // rail; one axis in eight gets a fully random word
                for (int a = 0; a < NAXES; a++)
                begin
                    if ($urandom_range(7) == 0)
                        word[a] = $urandom;
                    else
                    begin
                        reach   = $urandom_range(20);
                        word[a] = target[a] + ($urandom_range(1 << (reach + 1))
                                               - (1 << reach));
                    end
                end
                send_word(word, 1'b0, '0);
                if (phase == PRESSURE_PHASE && n % 40 == 20)
                    hold_req = 1'b1;
            end
        end

        settle();
        repeat (LATENCY * 4) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
